/* rtl/tae_pkg.sv */
// Shared types and codes for the tile allocator with age eviction.
// No dependencies; every other file in rtl/ but tae_ram refers to this package by scoped name.
package tae_pkg;

	// Operation codes on the input channel
	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE  = 2'd1;
	localparam logic [1:0] OP_PLAN  = 2'd2;

	// Result status codes
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_NOFREE  = 2'd1;
	localparam logic [1:0] STATUS_IGNORED = 2'd2;

	// Block size register reset value
	localparam logic [15:0] TPB_RESET = 16'd16;

	// Window divider: 17-bit dividend, 16-bit divisor, one quotient bit per step
	localparam int DIV_W     = 17;
	localparam int DEN_W     = 16;
	localparam int DIV_STEPS = 17;
	localparam int DCNT_W    = 5;

	// Sequencer states
	typedef enum logic [6:0] {
		ST_CLEAR   = 7'b0000001,
		ST_IDLE    = 7'b0000010,
		ST_ALLOC_RD = 7'b0000100,
		ST_FREE_RD = 7'b0001000,
		ST_DIV     = 7'b0010000,
		ST_SWEEP   = 7'b0100000,
		ST_DONE    = 7'b1000000
	} tae_state_t;

	// Divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} tae_div_stat_t;

endpackage

/* rtl/tae_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module tae_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write, and register the read data (old data on a same-address collision)
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/tae_div.sv */
// Iterative restoring divider, one quotient bit per cycle, for the window rounding.
// Depends on tae_pkg for widths, step count and the status struct.
module tae_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [tae_pkg::DIV_W-1:0]     num,
	input  logic [tae_pkg::DEN_W-1:0]     den,
	output logic [tae_pkg::DIV_W-1:0]     quot,
	output tae_pkg::tae_div_stat_t        stat
);

	logic [tae_pkg::DIV_W-1:0]  rem_q;
	logic [tae_pkg::DIV_W-1:0]  quo_q;
	logic [tae_pkg::DEN_W-1:0]  den_q;
	logic [tae_pkg::DCNT_W-1:0] cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [tae_pkg::DIV_W:0]    rem_sh;
	logic [tae_pkg::DIV_W:0]    diff;
	logic                       ge;

	// Shift in the next dividend bit and trial-subtract the divisor
	always_comb begin
		rem_sh = {rem_q, quo_q[tae_pkg::DIV_W-1]};
		diff   = rem_sh - (tae_pkg::DIV_W+1)'(den_q);
		ge     = ~diff[tae_pkg::DIV_W];
	end

	// Step the quotient one bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			quo_q  <= '0;
			den_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= '0;
				quo_q  <= num;
				den_q  <= den;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= ge ? diff[tae_pkg::DIV_W-1:0] : rem_sh[tae_pkg::DIV_W-1:0];
				quo_q <= {quo_q[tae_pkg::DIV_W-2:0], ge};
				cnt_q <= cnt_q + tae_pkg::DCNT_W'(1);
				if (cnt_q == tae_pkg::DCNT_W'(tae_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign quot      = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

/* rtl/tile_allocator_age_evict_unit.sv */
// Top level of the tile allocator: sequencer, free stack, tile table and window divider.
// Depends on tae_pkg, tae_ram and tae_div.
//
// Tile allocator with age eviction. Tiles are handed out from a LIFO free stack that starts
// full with tiles 0 to NUM_TILES-1, so the first alloc returns the highest index. Each
// accepted beat gives exactly one result beat. After reset the tile table is cleared one entry
// a cycle, and in_ready stays low until that is done (configuration writes are taken at any
// time). Alloc and free pass through the registered read of the stack or tile table, then the
// done state and the output register; a failed alloc and the unused code skip the read.
// Plan runs the bit-serial divider that rounds the window into blocks (17 quotient steps and
// its done flag), then a sweep that reads one tile entry per cycle through the table's
// single read port. in_ready is low
// while an item is in work; a finished result waits in the output register and does not hold
// up the next item until a second result is ready.
module tile_allocator_age_evict_unit #(
	parameter int NUM_TILES   = 64,
	parameter int TILE_STRIDE = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [7:0]  layer_index,
	input  logic [7:0]  head_index,
	input  logic [5:0]  tile_number,
	input  logic [15:0] window_tokens,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [5:0]  granted_tile,
	output logic [11:0] tile_base,
	output logic [6:0]  free_tiles,
	output logic [6:0]  evicted_count
);

	localparam int IDX_W = (NUM_TILES > 1) ? $clog2(NUM_TILES) : 1;
	localparam int CNT_W = $clog2(NUM_TILES + 1);
	localparam int ENT_W = 33;
	localparam logic [CNT_W-1:0] NT_CNT = CNT_W'(NUM_TILES);

	tae_pkg::tae_state_t state_q;

	logic [CNT_W-1:0]  depth_q;
	logic [CNT_W-1:0]  lw_q;
	logic [31:0]       frame_q;
	logic [16:0]       win_q;
	logic [15:0]       tpb_q;
	logic [CNT_W-1:0]  idx_q;
	logic              chk_v_s1;
	logic [IDX_W-1:0]  chk_idx_s1;
	logic [CNT_W-1:0]  ev_cnt_q;
	logic              free_ok_q;
	logic [IDX_W-1:0]  free_addr_q;
	logic [15:0]       meta_q;
	logic [1:0]        res_status_q;
	logic [5:0]        res_grant_q;
	logic [11:0]       res_start_q;
	logic              out_valid_q;
	logic [1:0]        out_status_q;
	logic [5:0]        out_grant_q;
	logic [11:0]       out_start_q;
	logic [6:0]        out_free_q;
	logic [6:0]        out_evict_q;

	logic                          accept;
	logic [15:0]                   b_eff;
	logic [tae_pkg::DIV_W-1:0]     div_num;
	logic [tae_pkg::DIV_W-1:0]     div_quot;
	tae_pkg::tae_div_stat_t        div_stat;
	logic                          div_start;
	logic                          tile_in_range;
	logic [CNT_W-1:0]              pop_pos;
	logic [IDX_W-1:0]              alloc_tile;
	logic [23:0]                   alloc_prod;
	logic                          ent_res;
	logic [31:0]                   ent_last;
	logic [32:0]                   age_sum;
	logic                          evict_hit;
	logic                          free_take;
	logic                          out_load;

	logic              stk_we;
	logic [IDX_W-1:0]  stk_waddr;
	logic [IDX_W-1:0]  stk_wdata;
	logic [IDX_W-1:0]  stk_raddr;
	logic [IDX_W-1:0]  stk_rdata;
	logic              ent_we;
	logic [IDX_W-1:0]  ent_waddr;
	logic [ENT_W-1:0]  ent_wdata;
	logic [IDX_W-1:0]  ent_raddr;
	logic [ENT_W-1:0]  ent_rdata;
	logic              meta_we;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == tae_pkg::ST_IDLE);
	assign accept    = in_valid & in_ready;

	// Round the window up to whole blocks; a zero block size counts as one
	assign b_eff     = (tpb_q == 16'd0) ? 16'd1 : tpb_q;
	assign div_num   = 17'(window_tokens) + 17'(b_eff) - 17'd1;
	assign div_start = accept && (operation == tae_pkg::OP_PLAN);

	tae_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (b_eff),
		.quot   (div_quot),
		.stat   (div_stat)
	);

	// Free requests beyond the pool are ignored
	assign tile_in_range = (13'(tile_number) < 13'(NUM_TILES));

	// Stack slots below the low-water mark were never rewritten and still hold their index
	assign pop_pos    = depth_q - CNT_W'(1);
	assign alloc_tile = (pop_pos < lw_q) ? IDX_W'(pop_pos) : stk_rdata;
	assign alloc_prod = 24'(alloc_tile) * 24'(TILE_STRIDE);

	// Age test on the entry under check, widened so the sum cannot wrap
	assign ent_res   = ent_rdata[32];
	assign ent_last  = ent_rdata[31:0];
	assign age_sum   = {1'b0, ent_last} + 33'(win_q);
	assign evict_hit = (state_q == tae_pkg::ST_SWEEP) && chk_v_s1 && ent_res &&
		(age_sum < {1'b0, frame_q}) && (depth_q != NT_CNT);
	assign free_take = free_ok_q && ent_res && (depth_q != NT_CNT);

	assign stk_raddr = IDX_W'(pop_pos);
	assign ent_raddr = (state_q == tae_pkg::ST_IDLE) ? IDX_W'(tile_number) : IDX_W'(idx_q);
	assign meta_we   = (state_q == tae_pkg::ST_ALLOC_RD);

	// Steer the write ports of the stack and the tile table
	always_comb begin
		stk_we    = 1'b0;
		stk_waddr = IDX_W'(depth_q);
		stk_wdata = '0;
		ent_we    = 1'b0;
		ent_waddr = '0;
		ent_wdata = '0;
		case (state_q)
			tae_pkg::ST_CLEAR: begin
				ent_we    = 1'b1;
				ent_waddr = IDX_W'(idx_q);
			end
			tae_pkg::ST_ALLOC_RD: begin
				ent_we    = 1'b1;
				ent_waddr = alloc_tile;
				ent_wdata = {1'b1, frame_q};
			end
			tae_pkg::ST_FREE_RD: begin
				if (free_take) begin
					ent_we    = 1'b1;
					ent_waddr = free_addr_q;
					ent_wdata = {1'b0, ent_last};
					stk_we    = 1'b1;
					stk_wdata = free_addr_q;
				end
			end
			tae_pkg::ST_SWEEP: begin
				if (evict_hit) begin
					ent_we    = 1'b1;
					ent_waddr = chk_idx_s1;
					ent_wdata = {1'b0, ent_last};
					stk_we    = 1'b1;
					stk_wdata = chk_idx_s1;
				end
			end
			default: begin
			end
		endcase
	end

	tae_ram #(.WIDTH(IDX_W), .DEPTH(NUM_TILES)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	tae_ram #(.WIDTH(ENT_W), .DEPTH(NUM_TILES)) u_table (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

	// Layer and head of each tile, recorded on alloc
	tae_ram #(.WIDTH(16), .DEPTH(NUM_TILES)) u_meta (
		.clk   (clk),
		.we    (meta_we),
		.waddr (alloc_tile),
		.wdata (meta_q),
		.raddr (alloc_tile),
		.rdata ()
	);

	assign out_load = (state_q == tae_pkg::ST_DONE) && (!out_valid_q || out_ready);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= tae_pkg::ST_CLEAR;
			depth_q      <= NT_CNT;
			lw_q         <= NT_CNT;
			frame_q      <= '0;
			win_q        <= '0;
			tpb_q        <= tae_pkg::TPB_RESET;
			idx_q        <= '0;
			chk_v_s1     <= 1'b0;
			chk_idx_s1   <= '0;
			ev_cnt_q     <= '0;
			free_ok_q    <= 1'b0;
			free_addr_q  <= '0;
			meta_q       <= '0;
			res_status_q <= tae_pkg::STATUS_OK;
			res_grant_q  <= '0;
			res_start_q  <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= tae_pkg::STATUS_OK;
			out_grant_q  <= '0;
			out_start_q  <= '0;
			out_free_q   <= '0;
			out_evict_q  <= '0;
		end else begin
			if (cfg_valid) begin
				tpb_q <= cfg_data;
			end
			// Raise valid on a new result, drop it once the beat is taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				tae_pkg::ST_CLEAR: begin
					idx_q <= idx_q + CNT_W'(1);
					if (idx_q == CNT_W'(NUM_TILES - 1)) begin
						state_q <= tae_pkg::ST_IDLE;
					end
				end
				tae_pkg::ST_IDLE: begin
					if (accept) begin
						meta_q       <= {layer_index, head_index};
						ev_cnt_q     <= '0;
						res_status_q <= ((operation == tae_pkg::OP_ALLOC) && (depth_q == '0)) ?
							tae_pkg::STATUS_NOFREE : tae_pkg::STATUS_OK;
						res_grant_q  <= '0;
						res_start_q  <= '0;
						case (operation)
							tae_pkg::OP_ALLOC: begin
								if (depth_q == '0) begin
									state_q <= tae_pkg::ST_DONE;
								end else begin
									state_q <= tae_pkg::ST_ALLOC_RD;
								end
							end
							tae_pkg::OP_FREE: begin
								free_ok_q   <= tile_in_range;
								free_addr_q <= IDX_W'(tile_number);
								state_q     <= tae_pkg::ST_FREE_RD;
							end
							tae_pkg::OP_PLAN: begin
								frame_q <= frame_q + 32'd1;
								state_q <= tae_pkg::ST_DIV;
							end
							default: begin
								state_q <= tae_pkg::ST_DONE;
							end
						endcase
					end
				end
				tae_pkg::ST_ALLOC_RD: begin
					depth_q     <= pop_pos;
					res_grant_q <= 6'(alloc_tile);
					res_start_q <= alloc_prod[11:0];
					if (pop_pos < lw_q) begin
						lw_q <= pop_pos;
					end
					state_q <= tae_pkg::ST_DONE;
				end
				tae_pkg::ST_FREE_RD: begin
					if (free_take) begin
						depth_q <= depth_q + CNT_W'(1);
					end else begin
						res_status_q <= tae_pkg::STATUS_IGNORED;
					end
					state_q <= tae_pkg::ST_DONE;
				end
				tae_pkg::ST_DIV: begin
					if (div_stat.done) begin
						win_q   <= div_quot;
						idx_q   <= '0;
						state_q <= tae_pkg::ST_SWEEP;
					end
				end
				tae_pkg::ST_SWEEP: begin
					// Issue the next read while checking the previous entry
					chk_v_s1   <= (idx_q != NT_CNT);
					chk_idx_s1 <= IDX_W'(idx_q);
					if (idx_q != NT_CNT) begin
						idx_q <= idx_q + CNT_W'(1);
					end
					if (evict_hit) begin
						depth_q  <= depth_q + CNT_W'(1);
						ev_cnt_q <= ev_cnt_q + CNT_W'(1);
					end
					if (chk_v_s1 && (chk_idx_s1 == IDX_W'(NUM_TILES - 1))) begin
						state_q <= tae_pkg::ST_DONE;
					end
				end
				tae_pkg::ST_DONE: begin
					if (out_load) begin
						out_status_q <= res_status_q;
						out_grant_q  <= res_grant_q;
						out_start_q  <= res_start_q;
						out_free_q   <= 7'(depth_q);
						out_evict_q  <= 7'(ev_cnt_q);
						state_q      <= tae_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= tae_pkg::ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign granted_tile  = out_grant_q;
	assign tile_base     = out_start_q;
	assign free_tiles    = out_free_q;
	assign evicted_count = out_evict_q;

endmodule

/* rtl/tae_checker.sv */
// Port-level checks for the tile allocator, attached to the top level by bind.
// Depends on tae_pkg for status codes and on tile_allocator_age_evict_unit's ports.
module tae_checker #(
	parameter int NUM_TILES = 64
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic [5:0]  granted_tile,
	input logic [11:0] tile_base,
	input logic [6:0]  free_tiles,
	input logic [6:0]  evicted_count
);

	// Hold a stalled result beat
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
		$stable(granted_tile) && $stable(tile_base) && $stable(free_tiles) &&
		$stable(evicted_count))
		else $error("stalled result beat changed");

	// One item in work at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in work");

	// Failed alloc grants nothing and leaves an empty stack
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == tae_pkg::STATUS_NOFREE) |->
		(granted_tile == 6'd0) && (tile_base == 12'd0) && (evicted_count == 7'd0) &&
		(free_tiles == 7'd0))
		else $error("failed alloc carries a grant");

	// Evictions come only from a plan, which grants nothing
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (evicted_count != 7'd0) |->
		(status == tae_pkg::STATUS_OK) && (granted_tile == 6'd0) && (tile_base == 12'd0))
		else $error("evicted count on a non-plan result");

	// Free depth never exceeds the pool
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (NUM_TILES < 128) |-> (32'(free_tiles) <= 32'(NUM_TILES)))
		else $error("free depth beyond pool size");

endmodule

bind tile_allocator_age_evict_unit tae_checker #(.NUM_TILES(NUM_TILES)) u_tae_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.status        (status),
	.granted_tile  (granted_tile),
	.tile_base     (tile_base),
	.free_tiles    (free_tiles),
	.evicted_count (evicted_count)
);

/* tb/tb_tile_allocator_age_evict_unit.sv */
`timescale 1ns / 1ps
// Self-checking testbench for tile_allocator_age_evict_unit: a tile pool tracker predicts
// every result beat, and random valid/ready traffic is run under several block sizes.
// Depends on tae_pkg and the RTL top level.
module tb_tile_allocator_age_evict_unit;

	localparam int NUM_TILES     = 64;
	localparam int TILE_STRIDE   = 64;
	localparam int CYCLE_LIMIT   = 700000;
	localparam int TAIL_CYCLES   = 150;
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 145;
	localparam int HOLD_AT_BEAT  = 350;
	localparam int HOLD_CYCLES   = 400;
	localparam logic [1:0] OP_SPARE = 2'd3;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  layer;
		logic [7:0]  head;
		logic [5:0]  tile;
		logic [15:0] window;
	} tile_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  granted;
		logic [11:0] start;
		logic [6:0]  free_tiles;
		logic [6:0]  evicted;
	} tile_result_t;

	// Tracks the free stack, residency and frame ages; queues the result of each request
	class tile_pool_tracker;
		logic [5:0]   stack_mem[NUM_TILES];
		int unsigned  depth;
		bit           resident[NUM_TILES];
		logic [31:0]  alloc_frame[NUM_TILES];
		logic [31:0]  frame;
		logic [16:0]  win_blocks;
		logic [15:0]  block_tokens;
		tile_result_t pending_results[$];
		int           errors;

		function new();
			for (int i = 0; i < NUM_TILES; i++) begin
				stack_mem[i] = 6'(i);
				resident[i] = 1'b0;
				alloc_frame[i] = '0;
			end
			depth = NUM_TILES;
			frame = '0;
			win_blocks = '0;
			block_tokens = tae_pkg::TPB_RESET;
			errors = 0;
		endfunction

		function void set_block_tokens(logic [15:0] v);
			block_tokens = v;
		endfunction

		// Push a resident tile back on the free stack
		function bit release_tile(int unsigned t);
			if (t >= NUM_TILES || !resident[t] || depth >= NUM_TILES) return 1'b0;
			resident[t] = 1'b0;
			stack_mem[depth] = 6'(t);
			depth++;
			return 1'b1;
		endfunction

		// Random resident tile, or -1 when the pool is fully free
		function int pick_resident();
			int list[$];
			for (int i = 0; i < NUM_TILES; i++)
				if (resident[i]) list.push_back(i);
			if (list.size() == 0) return -1;
			return list[$urandom_range(0, list.size() - 1)];
		endfunction

		function void note_request(tile_req_t rq);
			tile_result_t res;
			int unsigned  t;
			int unsigned  b;
			int unsigned  evicted;
			res = '0;
			evicted = 0;
			case (rq.op)
				tae_pkg::OP_ALLOC: begin
					if (depth == 0) begin
						res.status = tae_pkg::STATUS_NOFREE;
					end else begin
						depth--;
						t = stack_mem[depth];
						resident[t] = 1'b1;
						alloc_frame[t] = frame;
						res.granted = 6'(t);
						res.start = 12'(t * TILE_STRIDE);
					end
				end
				tae_pkg::OP_FREE: begin
					if (!release_tile(rq.tile)) res.status = tae_pkg::STATUS_IGNORED;
				end
				tae_pkg::OP_PLAN: begin
					frame = frame + 32'd1;
					b = (block_tokens == 0) ? 1 : block_tokens;
					win_blocks = 17'((32'(rq.window) + b - 1) / b);
					// Sweep ascending; compare ages without wrap
					for (int i = 0; i < NUM_TILES; i++) begin
						if (resident[i] &&
						    64'(alloc_frame[i]) + 64'(win_blocks) < 64'(frame)) begin
							if (release_tile(i)) evicted++;
						end
					end
					res.evicted = 7'(evicted);
				end
				default: ;
			endcase
			res.free_tiles = 7'(depth);
			pending_results.push_back(res);
		endfunction

		function void compare_field(string field, int unsigned exp_v, int unsigned act_v);
			if (exp_v != act_v) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, got %0d",
					$time, field, exp_v, act_v);
			end
		endfunction

		function void check_result(tile_result_t got);
			tile_result_t want;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result beat, expected none, got %h", $time, got);
				return;
			end
			want = pending_results.pop_front();
			compare_field("status", want.status, got.status);
			compare_field("granted_tile", want.granted, got.granted);
			compare_field("tile_base", want.start, got.start);
			compare_field("free_tiles", want.free_tiles, got.free_tiles);
			compare_field("evicted_count", want.evicted, got.evicted);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  operation;
	logic [7:0]  layer_index;
	logic [7:0]  head_index;
	logic [5:0]  tile_number;
	logic [15:0] window_tokens;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic [5:0]  granted_tile;
	logic [11:0] tile_base;
	logic [6:0]  free_tiles;
	logic [6:0]  evicted_count;

	tile_pool_tracker tracker;
	int               cycle_count = 0;
	int               tx_burst = 0;
	int               rx_burst = 0;

	tile_allocator_age_evict_unit #(
		.NUM_TILES   (NUM_TILES),
		.TILE_STRIDE (TILE_STRIDE)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.layer_index   (layer_index),
		.head_index    (head_index),
		.tile_number   (tile_number),
		.window_tokens (window_tokens),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.granted_tile  (granted_tile),
		.tile_base     (tile_base),
		.free_tiles    (free_tiles),
		.evicted_count (evicted_count)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Check every result beat against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.check_result(tile_result_t'({status, granted_tile, tile_base,
				free_tiles, evicted_count}));
	end

	// Idle length per beat, with occasional stretches of back-to-back beats
	function automatic int pick_gap(inout int burst);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0) burst = 25;
		return $urandom_range(0, 13);
	endfunction

	function automatic tile_req_t make_req(logic [1:0] op, logic [7:0] layer, logic [7:0] head,
			logic [5:0] tile, logic [15:0] window);
		tile_req_t rq;
		rq.op = op;
		rq.layer = layer;
		rq.head = head;
		rq.tile = tile;
		rq.window = window;
		return rq;
	endfunction

	task automatic send_request(input tile_req_t rq);
		int gap;
		gap = pick_gap(tx_burst);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= rq.op;
		layer_index <= rq.layer;
		head_index <= rq.head;
		tile_number <= rq.tile;
		window_tokens <= rq.window;
		do @(posedge clk); while (!in_ready);
		tracker.note_request(rq);
	endtask

	task automatic write_block_tokens(input logic [15:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		tracker.set_block_tokens(v);
		cfg_valid <= 1'b0;
	endtask

	// Drop valid and wait until every predicted beat has come back
	task automatic settle();
		in_valid <= 1'b0;
		while (tracker.pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic run_directed();
		send_request(make_req(OP_SPARE, 8'hFF, 8'hFF, 6'd63, 16'hFFFF));
		send_request(make_req(OP_SPARE, 8'h00, 8'h00, 6'd0, 16'h0000));
		// frees of tiles that were never handed out
		send_request(make_req(tae_pkg::OP_FREE, 8'h00, 8'h00, 6'd63, 16'h0000));
		send_request(make_req(tae_pkg::OP_FREE, 8'hFF, 8'hFF, 6'd0, 16'hFFFF));
		send_request(make_req(tae_pkg::OP_ALLOC, 8'h00, 8'h00, 6'd0, 16'h0000));
		send_request(make_req(tae_pkg::OP_ALLOC, 8'hFF, 8'hFF, 6'd63, 16'hFFFF));
		send_request(make_req(tae_pkg::OP_FREE, 8'h00, 8'h00, 6'd63, 16'h0000));
		// double free is ignored
		send_request(make_req(tae_pkg::OP_FREE, 8'h00, 8'h00, 6'd63, 16'h0000));
		send_request(make_req(tae_pkg::OP_ALLOC, 8'hA5, 8'h5A, 6'd21, 16'h0000));
		// zero window evicts everything older than this frame
		send_request(make_req(tae_pkg::OP_PLAN, 8'h00, 8'h00, 6'd0, 16'h0000));
		send_request(make_req(tae_pkg::OP_ALLOC, 8'h5A, 8'hA5, 6'd42, 16'h0000));
		send_request(make_req(tae_pkg::OP_ALLOC, 8'h01, 8'h80, 6'd1, 16'h0000));
		send_request(make_req(tae_pkg::OP_PLAN, 8'h00, 8'h00, 6'd0, 16'hFFFF));
		send_request(make_req(tae_pkg::OP_PLAN, 8'h00, 8'h00, 6'd0, 16'd1));
		send_request(make_req(tae_pkg::OP_ALLOC, 8'hF0, 8'h0F, 6'd0, 16'h0000));
		// window of exactly one block, then one token past it
		send_request(make_req(tae_pkg::OP_PLAN, 8'h00, 8'h00, 6'd0, 16'd16));
		send_request(make_req(tae_pkg::OP_PLAN, 8'h00, 8'h00, 6'd0, 16'd17));
		send_request(make_req(tae_pkg::OP_PLAN, 8'h00, 8'h00, 6'd0, 16'd32));
		send_request(make_req(tae_pkg::OP_FREE, 8'h00, 8'h00, 6'd42, 16'h0000));
		send_request(make_req(tae_pkg::OP_ALLOC, 8'h0F, 8'hF0, 6'd21, 16'h5555));
		send_request(make_req(tae_pkg::OP_FREE, 8'h00, 8'h00, 6'd63, 16'hAAAA));
	endtask

	// Weighted random traffic; mode 0 drives the pool empty, mode 2 leans on plans
	task automatic run_random(input int mode, input int count);
		tile_req_t rq;
		int        r;
		int        alloc_pct;
		int        free_pct;
		int        plan_pct;
		int        wide_pct;
		int        b;
		int        hi;
		int        pick;
		alloc_pct = (mode == 0) ? 72 : (mode == 1) ? 45 : 40;
		free_pct  = (mode == 0) ? 12 : (mode == 1) ? 35 : 26;
		plan_pct  = (mode == 0) ? 12 : (mode == 1) ? 16 : 30;
		wide_pct  = (mode == 0) ? 50 : 12;
		for (int n = 0; n < count; n++) begin
			rq.layer = 8'($urandom);
			rq.head = 8'($urandom);
			rq.tile = 6'($urandom);
			rq.window = 16'($urandom);
			r = $urandom_range(0, 99);
			if (r < alloc_pct) begin
				rq.op = tae_pkg::OP_ALLOC;
			end else if (r < alloc_pct + free_pct) begin
				rq.op = tae_pkg::OP_FREE;
				pick = tracker.pick_resident();
				if (pick >= 0 && $urandom_range(0, 99) < 85) rq.tile = 6'(pick);
			end else if (r < alloc_pct + free_pct + plan_pct) begin
				rq.op = tae_pkg::OP_PLAN;
				b = (tracker.block_tokens == 0) ? 1 : int'(tracker.block_tokens);
				hi = (3 * b > 65535) ? 65535 : 3 * b;
				r = $urandom_range(0, 99);
				if (r >= wide_pct)
					rq.window = (r < wide_pct + 30) ? 16'($urandom_range(0, 15))
						: 16'($urandom_range(0, hi));
			end else begin
				rq.op = OP_SPARE;
			end
			send_request(rq);
		end
	endtask

	// Result side: random stalls, and one long hold-off so the block backs up
	initial begin : result_sink
		int gap;
		int beats;
		beats = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			gap = (beats == HOLD_AT_BEAT) ? HOLD_CYCLES : pick_gap(rx_burst);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			beats++;
		end
	end

	initial begin : stimulus
		logic [15:0] setting;
		tracker = new();
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		operation = tae_pkg::OP_ALLOC;
		layer_index = '0;
		head_index = '0;
		tile_number = '0;
		window_tokens = '0;
		out_ready = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		// Block size sweeps zero, both extremes, the reset value and random values
		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			case (ph)
				0: setting = 16'd0;
				1: setting = 16'd1;
				2: setting = 16'hFFFF;
				3: setting = tae_pkg::TPB_RESET;
				7: setting = 16'($urandom_range(1, 65535));
				default: setting = 16'($urandom_range(1, 64));
			endcase
			write_block_tokens(setting);
			run_random(ph % 3, PHASE_ITEMS);
		end
		settle();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (tracker.errors == 0 && tracker.pending_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
